// ===== src/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ===== src/ffha_pkg.sv =====
// Shared types, codes and defaults for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int ADDR_BITS_DEF  = 32;
    localparam logic [31:0] CAP_RESET = 32'd65536;
    localparam logic [6:0]  HDR_RESET = 7'd24;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_REALLOC = 2'd2;
    localparam logic [1:0] FUNC_QUERY   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_NOTALLOC = 3'd4;

    localparam logic CFG_CAP = 1'b0;
    localparam logic CFG_HDR = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK_RD, S_LOOK_CHK, S_LOOK_ACT,
        S_FIT_RD, S_FIT_CHK, S_APPEND, S_DONE, S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input word
        logic scan_clr;    // index := 0
        logic scan_inc;    // index := index + 1
        logic rd;          // read table at index
        logic look_hit;    // remember index as old block
        logic fit_take;    // mark found entry allocated, set result
        logic append;      // append block at heap top
        logic free_old;    // mark old block free
        logic set_st;      // write status code
        logic [2:0] st;
        logic set_bytes;   // report old block size
        logic set_copy;
        logic set_res_in;  // result := input address
        logic out_load;    // move result into output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic addr_zero;
        logic size_zero;
        logic scan_end;    // index reached entry count
        logic match;       // entry at index matches address
        logic ent_free;
        logic fits;        // entry free and big enough
        logic full;        // table full
        logic heap_ok;     // append stays within capacity
        logic big_enough;  // old block holds request
        logic out_busy;
    } dp_sts_t;
endpackage

// ===== src/ffha_ctrl.sv =====
// Controller state machine of the first-fit heap allocator.
// Depends on ffha_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffha_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ffha_pkg::dp_sts_t  sts,
    output ffha_pkg::dp_cmd_t  cmd
);
    ffha_pkg::state_t state_reg, state_next;
    logic realloc_reg, realloc_next;   // looking for a new block for a realloc

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffha_pkg::S_IDLE;
            realloc_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            realloc_reg <= realloc_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        realloc_next = realloc_reg;
        unique case (state_reg)
            ffha_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    realloc_next = 1'b0;
                    state_next   = ffha_pkg::S_OUT;
                end
            end
            ffha_pkg::S_OUT: begin
                if (sts.func == ffha_pkg::FUNC_ALLOC ||
                    (sts.func == ffha_pkg::FUNC_REALLOC && sts.addr_zero)) begin
                    state_next = sts.size_zero ? ffha_pkg::S_DONE : ffha_pkg::S_FIT_RD;
                end else if (sts.addr_zero) begin
                    state_next = ffha_pkg::S_DONE;
                end else begin
                    state_next = ffha_pkg::S_LOOK_RD;
                end
            end
            ffha_pkg::S_LOOK_RD: begin
                state_next = sts.scan_end ? ffha_pkg::S_DONE : ffha_pkg::S_LOOK_CHK;
            end
            ffha_pkg::S_LOOK_CHK: begin
                state_next = sts.match ? ffha_pkg::S_LOOK_ACT : ffha_pkg::S_LOOK_RD;
            end
            ffha_pkg::S_LOOK_ACT: begin
                if (!sts.ent_free && sts.func == ffha_pkg::FUNC_REALLOC &&
                    !sts.big_enough) begin
                    realloc_next = 1'b1;
                    state_next   = ffha_pkg::S_FIT_RD;
                end else begin
                    state_next = ffha_pkg::S_DONE;
                end
            end
            ffha_pkg::S_FIT_RD: begin
                state_next = sts.scan_end ? ffha_pkg::S_APPEND : ffha_pkg::S_FIT_CHK;
            end
            ffha_pkg::S_FIT_CHK: begin
                state_next = sts.fits ? ffha_pkg::S_DONE : ffha_pkg::S_FIT_RD;
            end
            ffha_pkg::S_APPEND: state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_DONE: begin
                if (!sts.out_busy) state_next = ffha_pkg::S_IDLE;
            end
            default: state_next = ffha_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ffha_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ffha_pkg::S_OUT: begin
                cmd.scan_clr = 1'b1;
                if (sts.func == ffha_pkg::FUNC_ALLOC ||
                    (sts.func == ffha_pkg::FUNC_REALLOC && sts.addr_zero)) begin
                    if (sts.size_zero) begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ffha_pkg::ST_ZERO;
                    end
                end else if (!sts.addr_zero) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ffha_pkg::ST_UNKNOWN;
                end
            end
            ffha_pkg::S_LOOK_RD: cmd.rd = !sts.scan_end;
            ffha_pkg::S_LOOK_CHK: begin
                cmd.scan_inc = !sts.match;
                cmd.look_hit = sts.match;
            end
            ffha_pkg::S_LOOK_ACT: begin
                cmd.set_st = 1'b1;
                cmd.st     = ffha_pkg::ST_OK;
                if (sts.ent_free) begin
                    cmd.st = ffha_pkg::ST_NOTALLOC;
                end else begin
                    unique case (sts.func)
                        ffha_pkg::FUNC_FREE:  cmd.free_old  = 1'b1;
                        ffha_pkg::FUNC_QUERY: cmd.set_bytes = 1'b1;
                        ffha_pkg::FUNC_REALLOC: begin
                            cmd.set_res_in = sts.big_enough;
                            cmd.scan_clr   = !sts.big_enough;
                        end
                        default: ;
                    endcase
                end
            end
            ffha_pkg::S_FIT_RD: cmd.rd = !sts.scan_end;
            ffha_pkg::S_FIT_CHK: begin
                cmd.scan_inc = !sts.fits;
                cmd.fit_take = sts.fits;
                if (sts.fits && realloc_reg) begin
                    cmd.free_old  = 1'b1;
                    cmd.set_bytes = 1'b1;
                    cmd.set_copy  = 1'b1;
                end
            end
            ffha_pkg::S_APPEND: begin
                cmd.set_st = 1'b1;
                if (sts.full || !sts.heap_ok) begin
                    cmd.st = ffha_pkg::ST_NOSPACE;
                end else begin
                    cmd.st     = ffha_pkg::ST_OK;
                    cmd.append = 1'b1;
                    if (realloc_reg) begin
                        cmd.free_old  = 1'b1;
                        cmd.set_bytes = 1'b1;
                        cmd.set_copy  = 1'b1;
                    end
                end
            end
            ffha_pkg::S_DONE: cmd.out_load = !sts.out_busy;
            default: ;
        endcase
    end

    `ASSERT_CLK(a_ready_idle, aclk, aresetn,
        s_tready |-> state_reg == ffha_pkg::S_IDLE, "ready outside idle")
    `ASSERT_CLK(a_one_write, aclk, aresetn,
        !(cmd.fit_take && cmd.append), "take and append together")
    `ASSERT_CLK(a_done_idle, aclk, aresetn,
        cmd.out_load |=> state_reg == ffha_pkg::S_IDLE, "no return to idle")
endmodule

// ===== src/ffha_datapath.sv =====
// Datapath of the first-fit heap allocator: block table, scan index, result.
// Depends on ffha_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffha_datapath #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ffha_pkg::ADDR_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic [71:0]        s_tdata,
    input  ffha_pkg::dp_cmd_t  cmd,
    output ffha_pkg::dp_sts_t  sts,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [71:0]        m_tdata
);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = 65;   // start, bytes, free

    logic [31:0] cap_reg;
    logic [6:0]  hdr_reg;
    logic [1:0]  func_reg;
    logic [31:0] size_reg, addr_reg;
    logic [CW-1:0] count_reg, idx_reg, old_reg;
    logic [ADDR_BITS-1:0] top_reg;
    logic [EW-1:0] mem [MAX_BLOCKS];
    logic [EW-1:0] rd_reg;
    logic [31:0] old_bytes_reg;
    logic [31:0] res_reg, bytes_reg;
    logic [2:0]  st_reg;
    logic        copy_reg;
    logic        m_valid_reg;
    logic [71:0] m_data_reg;

    logic [6:0]  hdr_eff;
    logic [ADDR_BITS-1:0] start_q;
    logic [31:0] ent_bytes;
    logic [ADDR_BITS+33:0] end_sum, cap_eff;
    logic [ADDR_BITS-1:0] addr_mask;
    logic [ADDR_BITS+1:0] hdr_sum;
    logic [IW-1:0] wr_idx;
    logic [EW-1:0] wr_data;
    logic wr_en;

    assign hdr_eff   = (hdr_reg == 7'd0) ? 7'd1 : hdr_reg;
    assign start_q   = ADDR_BITS'(rd_reg[31:0]);
    assign ent_bytes = rd_reg[63:32];
    assign hdr_sum   = (ADDR_BITS+2)'(start_q) + (ADDR_BITS+2)'(hdr_eff);
    assign addr_mask = '1;
    assign end_sum   = (ADDR_BITS+34)'(top_reg) + (ADDR_BITS+34)'(hdr_eff)
                     + (ADDR_BITS+34)'(size_reg);
    assign cap_eff   = ((ADDR_BITS+34)'(cap_reg) < (ADDR_BITS+34)'(addr_mask))
                     ? (ADDR_BITS+34)'(cap_reg) : (ADDR_BITS+34)'(addr_mask);

    always_comb begin
        sts.func       = func_reg;
        sts.addr_zero  = (addr_reg == 32'd0);
        sts.size_zero  = (size_reg == 32'd0);
        sts.scan_end   = (idx_reg >= count_reg);
        sts.match      = (hdr_sum == (ADDR_BITS+2)'(addr_reg));
        sts.ent_free   = rd_reg[64];
        sts.fits       = rd_reg[64] && (ent_bytes >= size_reg);
        sts.full       = (count_reg >= CW'(MAX_BLOCKS));
        sts.heap_ok    = (end_sum <= cap_eff);
        sts.big_enough = (ent_bytes >= size_reg);
        sts.out_busy   = m_valid_reg && !m_tready;
    end

    // single write port: take, append or free of old block
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = IW'(idx_reg);
        wr_data = {1'b0, rd_reg[63:0]};
        if (cmd.append) begin
            wr_en   = 1'b1;
            wr_idx  = IW'(count_reg);
            wr_data = {1'b0, size_reg, 32'(top_reg)};
        end else if (cmd.fit_take) begin
            wr_en = 1'b1;
        end else if (cmd.free_old) begin
            wr_en   = 1'b1;
            wr_idx  = IW'(old_reg);
            wr_data = {1'b1, rd_reg[63:0]};
        end
    end

    // old block freed on realloc move needs a second write; done via flag
    logic pend_free_reg;
    logic [63:0] old_ent_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_idx] <= wr_data;
        else if (pend_free_reg) mem[IW'(old_reg)] <= {1'b1, old_ent_reg};
        if (cmd.rd) rd_reg <= mem[IW'(idx_reg)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= ffha_pkg::CAP_RESET;
            hdr_reg       <= ffha_pkg::HDR_RESET;
            count_reg     <= '0;
            top_reg       <= '0;
            m_valid_reg   <= 1'b0;
            pend_free_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == ffha_pkg::CFG_CAP) cap_reg <= cfg_data;
                else hdr_reg <= cfg_data[6:0];
            end
            if (cmd.append) begin
                count_reg <= count_reg + CW'(1);
                top_reg   <= ADDR_BITS'(end_sum);
            end
            pend_free_reg <= cmd.free_old && (cmd.fit_take || cmd.append);
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_tdata[1:0];
            size_reg  <= s_tdata[33:2];
            addr_reg  <= s_tdata[65:34];
            res_reg   <= '0;
            bytes_reg <= '0;
            copy_reg  <= 1'b0;
            st_reg    <= ffha_pkg::ST_OK;
        end
        if (cmd.scan_clr) idx_reg <= '0;
        else if (cmd.scan_inc) idx_reg <= idx_reg + CW'(1);
        if (cmd.look_hit) begin
            old_reg       <= idx_reg;
            old_bytes_reg <= ent_bytes;
            old_ent_reg   <= rd_reg[63:0];
        end
        if (cmd.set_st) st_reg <= cmd.st;
        if (cmd.set_res_in) res_reg <= addr_reg;
        if (cmd.fit_take) begin
            res_reg <= 32'(hdr_sum);
            st_reg  <= ffha_pkg::ST_OK;
        end
        if (cmd.append) res_reg <= 32'(top_reg) + 32'(hdr_eff);
        if (cmd.set_bytes) bytes_reg <= cmd.look_hit ? ent_bytes :
            ((cmd.fit_take || cmd.append) ? old_bytes_reg : ent_bytes);
        if (cmd.set_copy) copy_reg <= 1'b1;
        if (cmd.out_load)
            m_data_reg <= {4'd0, copy_reg, bytes_reg, st_reg, res_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `ASSERT_CLK(a_count_bound, aclk, aresetn,
        count_reg <= CW'(MAX_BLOCKS), "entry count past table")
    `ASSERT_CLK(a_append_room, aclk, aresetn,
        cmd.append |-> !sts.full, "append into full table")
    `ASSERT_CLK(a_out_hold, aclk, aresetn,
        (m_valid_reg && !m_tready) |=> m_valid_reg, "result dropped")
endmodule

// ===== src/first_fit_heap_allocator.sv =====
// First-fit heap allocator: top level joining controller and datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_datapath.
//
// Usage: one request word enters on s_*, one result word leaves on m_*.
// A request is allocate, free, reallocate or query size. Blocks live in a
// table of MAX_BLOCKS entries in address order; allocation takes the first
// free block that is big enough, else appends at the heap top.
// Timing: one word at a time. Each table entry is read and then compared
// on the single table port; a lookup scans the table once, an allocate
// scans it and may append, and a moving reallocate scans it twice. The next
// word can be taken in the cycle after the result is loaded. s_tready is
// high only while idle.
// Reset: synchronous, active low; the table empties, the heap top returns
// to 0 and both registers take their defaults (capacity 65536, header 24).
// Stall: the result waits in the output register while m_tready is low;
// the block holds the next finished result until it drains.
// Config: cfg_we/cfg_index/cfg_data write heap_capacity (0) or header_bytes
// (1); the user must write only while idle, the block does not enforce it.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ffha_pkg::ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // func[1:0], request_size[33:2], address[65:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // result_address[31:0], status[34:32],
                                   // block_bytes[66:35], copy_needed[67]
);
    ffha_pkg::dp_cmd_t cmd;
    ffha_pkg::dp_sts_t sts;

    ffha_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .sts, .cmd
    );

    ffha_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data, .s_tdata,
        .cmd, .sts, .m_tvalid, .m_tready, .m_tdata
    );
endmodule

// ===== bench/first_fit_heap_allocator_tb.sv =====
// Testbench for first_fit_heap_allocator: allocate, free, reallocate and size queries
// are driven on the request stream and every result word is checked against a local
// model of the block table. Depends on ffha_pkg and the allocator RTL.
module first_fit_heap_allocator_tb;
    localparam int NBLK = 64;
    localparam int WATCHDOG = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // func[1:0], request_size[33:2], address[65:34]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // result_address[31:0], status[34:32],
                                 // block_bytes[66:35], copy_needed[67]

    always #2 aclk = ~aclk;

    first_fit_heap_allocator i_dut (.*);

    // packed from the top bit down, so addr lands in the low bits
    typedef struct packed {
        logic        copy;
        logic [31:0] bytes;
        logic [2:0]  status;
        logic [31:0] addr;
    } reply_t;

    // Local copy of the block table and registers.
    logic [31:0] tbl_start [NBLK];
    logic [31:0] tbl_bytes [NBLK];
    logic        tbl_free  [NBLK];
    int          tbl_count;
    logic [31:0] top;
    logic [31:0] cap_reg;
    logic [6:0]  hdr_reg;

    reply_t      pending[$];
    logic [31:0] live[$];       // addresses given out and not yet freed
    int          errors = 0;
    int          idle_cycles = 0;
    int          words_sent = 0, words_seen = 0;
    int          n_nospace = 0, n_copy = 0, n_bad = 0;
    int          sink_wait = 0;
    bit          sink_stall_off = 0;

    function automatic logic [32:0] eff_hdr();
        return (hdr_reg == 0) ? 33'd1 : {26'd0, hdr_reg};
    endfunction

    function automatic int lookup(logic [31:0] a);
        for (int i = 0; i < tbl_count; i++)
            if ({1'b0, tbl_start[i]} + eff_hdr() == {1'b0, a}) return i;
        return -1;
    endfunction

    function automatic logic [2:0] first_fit(logic [31:0] sz, output logic [31:0] a);
        logic [33:0] fin;
        a = '0;
        if (sz == 0) return ffha_pkg::ST_ZERO;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_free[i] && tbl_bytes[i] >= sz) begin
                tbl_free[i] = 1'b0;
                a = tbl_start[i] + eff_hdr();
                return ffha_pkg::ST_OK;
            end
        if (tbl_count >= NBLK) return ffha_pkg::ST_NOSPACE;
        fin = {2'b0, top} + eff_hdr() + sz;
        if (fin > {2'b0, cap_reg}) return ffha_pkg::ST_NOSPACE;
        tbl_start[tbl_count] = top;
        tbl_bytes[tbl_count] = sz;
        tbl_free[tbl_count] = 1'b0;
        tbl_count++;
        a = top + eff_hdr();
        top = fin[31:0];
        return ffha_pkg::ST_OK;
    endfunction

    function automatic reply_t heap_predict(logic [1:0] fn, logic [31:0] sz,
                                            logic [31:0] a);
        reply_t r;
        int idx;
        logic [31:0] na;
        r = '0;
        if (fn == ffha_pkg::FUNC_ALLOC || (fn == ffha_pkg::FUNC_REALLOC && a == 0)) begin
            r.status = first_fit(sz, r.addr);
        end else if (a != 0) begin
            idx = lookup(a);
            if (idx < 0) r.status = ffha_pkg::ST_UNKNOWN;
            else if (tbl_free[idx]) r.status = ffha_pkg::ST_NOTALLOC;
            else if (fn == ffha_pkg::FUNC_FREE) tbl_free[idx] = 1'b1;
            else if (fn == ffha_pkg::FUNC_QUERY) r.bytes = tbl_bytes[idx];
            else if (tbl_bytes[idx] >= sz) r.addr = a;
            else begin
                r.status = first_fit(sz, na);
                if (r.status == ffha_pkg::ST_OK) begin
                    tbl_free[idx] = 1'b1;
                    r.addr = na;
                    r.bytes = tbl_bytes[idx];
                    r.copy = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Send one request word after a random gap, record its expected reply.
    // tvalid stays up after the accept until the next gap or drain drops it.
    task automatic send_req(logic [1:0] fn, logic [31:0] sz, logic [31:0] a);
        reply_t r;
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {6'd0, a, sz, fn};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = heap_predict(fn, sz, a);
        pending.push_back(r);
        words_sent++;
        if (r.status == ffha_pkg::ST_NOSPACE) n_nospace++;
        if (r.status >= ffha_pkg::ST_UNKNOWN) n_bad++;
        if (r.copy) n_copy++;
        // keep a list of live addresses to aim frees and reallocs at
        if (r.status == ffha_pkg::ST_OK && r.addr != 0 &&
            (fn == ffha_pkg::FUNC_ALLOC || fn == ffha_pkg::FUNC_REALLOC))
            if (r.addr != a) live.push_back(r.addr);
        if (r.status == ffha_pkg::ST_OK && (fn == ffha_pkg::FUNC_FREE || r.copy))
            foreach (live[i]) if (live[i] == a) begin live.delete(i); break; end
    endtask

    // Wait until the block is idle; write_reg then writes a register.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (4 * NBLK + 20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        drain();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == ffha_pkg::CFG_CAP) cap_reg = val; else hdr_reg = val[6:0];
    endtask

    function automatic logic [31:0] pick_live();
        if (live.size() == 0) return 32'd0;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom();
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    // Result checker and sink stalls.
    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[67:0];
            words_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.addr !== want.addr) begin
                    $error("result_address exp %h got %h", want.addr, got.addr); errors++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); errors++;
                end
                if (got.bytes !== want.bytes) begin
                    $error("block_bytes exp %h got %h", want.bytes, got.bytes); errors++;
                end
                if (got.copy !== want.copy) begin
                    $error("copy_needed exp %0d got %0d", want.copy, got.copy); errors++;
                end
            end
        end
        // after each word the sink holds off a drawn number of valid cycles
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            sink_wait = sink_stall_off ? 0 : $urandom_range(0, 5);
            m_tready <= (sink_wait == 0);
        end else if (m_tvalid && sink_wait > 0) begin
            sink_wait--;
            m_tready <= (sink_wait == 0);
        end else if (sink_wait == 0) begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: any accept on either side, a reset or a register write resets the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("first_fit_heap_allocator_tb: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] a0, a1;
        send_req(ffha_pkg::FUNC_ALLOC, 0, 0);              // zero size
        send_req(ffha_pkg::FUNC_FREE, 0, 0);               // null free
        send_req(ffha_pkg::FUNC_QUERY, 0, 0);              // null query
        send_req(ffha_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 0);  // no space
        send_req(ffha_pkg::FUNC_ALLOC, 100, 0);
        a0 = live[$];
        send_req(ffha_pkg::FUNC_REALLOC, 40, 0);           // null realloc allocates
        a1 = live[$];
        send_req(ffha_pkg::FUNC_QUERY, 0, a0);
        send_req(ffha_pkg::FUNC_REALLOC, 50, a0);          // in place
        send_req(ffha_pkg::FUNC_REALLOC, 0, a0);           // in place, size 0
        send_req(ffha_pkg::FUNC_REALLOC, 200, a0);         // moves, copy
        send_req(ffha_pkg::FUNC_FREE, 0, a0);              // already freed
        send_req(ffha_pkg::FUNC_QUERY, 0, a0);
        send_req(ffha_pkg::FUNC_ALLOC, 60, 0);             // reuses freed block
        send_req(ffha_pkg::FUNC_FREE, 0, 32'hFFFF_FFFF);   // unknown
        send_req(ffha_pkg::FUNC_QUERY, 0, 32'h1);
        send_req(ffha_pkg::FUNC_REALLOC, 32'hFFFF_FFFF, a1);  // failed realloc
        send_req(ffha_pkg::FUNC_QUERY, 0, a1);
        send_req(ffha_pkg::FUNC_FREE, 0, a1);
        send_req(ffha_pkg::FUNC_REALLOC, 5, a1);           // realloc of free block
    endtask

    // Fill the table to its limit with small blocks.
    task automatic test_table_full();
        for (int i = 0; i < NBLK + 4; i++)
            send_req(ffha_pkg::FUNC_ALLOC, $urandom_range(1, 8), 0);
        send_req(ffha_pkg::FUNC_ALLOC, 32'd100000, 0);
        send_req(ffha_pkg::FUNC_REALLOC, 32'd100000, pick_live());
    endtask

    task automatic test_random(int n);
        logic [31:0] a;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_req(ffha_pkg::FUNC_ALLOC, rand_size(), 0);
                3, 4:    send_req(ffha_pkg::FUNC_FREE, 0, pick_live());
                5, 6:    send_req(ffha_pkg::FUNC_REALLOC, rand_size(),
                                  ($urandom_range(0, 5) == 0) ? 32'd0 : pick_live());
                7:       send_req(ffha_pkg::FUNC_QUERY, $urandom(), pick_live());
                default: begin
                    // noise: random function and address, likely unknown
                    a = ($urandom_range(0, 1)) ? $urandom() : pick_live() + 1;
                    send_req($urandom_range(0, 3), $urandom(), a);
                end
            endcase
        end
    endtask

    // Reset the local model to the state after reset, then run the test phases.
    initial begin
        tbl_count = 0; top = '0;
        cap_reg = ffha_pkg::CAP_RESET; hdr_reg = ffha_pkg::HDR_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(300);

        // the sender holds off until every reply has drained
        drain();
        sink_stall_off = 1;
        test_random(50);
        sink_stall_off = 0;

        write_reg(ffha_pkg::CFG_HDR, 7'd0);     // header zero acts as one
        write_reg(ffha_pkg::CFG_CAP, 32'hFFFF_FFFF);
        test_table_full();
        test_random(250);

        write_reg(ffha_pkg::CFG_HDR, 7'd127);   // header above 64, addresses change meaning
        test_random(250);

        write_reg(ffha_pkg::CFG_CAP, 32'd0);    // nothing more can be appended
        write_reg(ffha_pkg::CFG_HDR, 7'd64);
        test_random(150);

        write_reg(ffha_pkg::CFG_CAP, 32'd70000);
        write_reg(ffha_pkg::CFG_HDR, 7'd1);
        test_random(450);

        drain();
        $display("covered %0d requests: %0d no-space, %0d copies, %0d bad addresses",
                 words_sent, n_nospace, n_copy, n_bad);
        $display("config phases: header 24/0/127/64/1, capacity reset/max/0/70000");
        if (errors == 0 && words_seen == words_sent)
            $display("first_fit_heap_allocator_tb: done, clean");
        else
            $display("first_fit_heap_allocator_tb: done, errors");
        $finish;
    end
endmodule

// ===== first_fit_heap_allocator.f =====
+incdir+src
src/ffha_pkg.sv
src/ffha_ctrl.sv
src/ffha_datapath.sv
src/first_fit_heap_allocator.sv
bench/first_fit_heap_allocator_tb.sv
